// File: hdl/plx_pkg.sv
// Shared types, constants and helper functions of the punctuation and number lexer.
`default_nettype none

package plx_pkg;

    // Default width of the source offset counters.
    localparam int DEFAULT_OFFSET_BITS = 16;

    // Token kinds as they appear on the result channel.
    localparam logic [3:0] KIND_LPAREN = 4'd0;
    localparam logic [3:0] KIND_RPAREN = 4'd1;
    localparam logic [3:0] KIND_LBRACE = 4'd2;
    localparam logic [3:0] KIND_RBRACE = 4'd3;
    localparam logic [3:0] KIND_SEMI   = 4'd4;
    localparam logic [3:0] KIND_COMMA  = 4'd5;
    localparam logic [3:0] KIND_DOT    = 4'd6;
    localparam logic [3:0] KIND_MINUS  = 4'd7;
    localparam logic [3:0] KIND_PLUS   = 4'd8;
    localparam logic [3:0] KIND_SLASH  = 4'd9;
    localparam logic [3:0] KIND_STAR   = 4'd10;
    localparam logic [3:0] KIND_NUMBER = 4'd11;
    localparam logic [3:0] KIND_EOF    = 4'd12;
    localparam logic [3:0] KIND_ERROR  = 4'd13;

    // Character codes the scanner looks at.
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Scanner modes; the pending ones hold lookahead across transfers.
    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_INT,
        MODE_INT_DOT,
        MODE_FRAC
    } scan_mode_t;

    // Input item.
    typedef struct packed {
        logic [7:0] char_code;
        logic       is_end;
    } in_t;

    // Result item.
    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_offset;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic        last_of_run;
    } out_t;

    // One token before the end-of-run flag is attached.
    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] offset;
        logic [15:0] length;
        logic [15:0] line;
    } tok_t;

    // All tokens caused by one input item, in emission order.
    typedef struct packed {
        logic [1:0]     count;
        tok_t [2:0]     slot;
    } bundle_t;

    // Saturate a counter value to the 16-bit result fields.
    function automatic logic [15:0] clamp16(input logic [31:0] v);
        return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

    // Map a punctuation character to its kind; bit 4 flags a match.
    function automatic logic [4:0] punct_lookup(input logic [7:0] c);
        logic [4:0] r;
        r = {1'b0, KIND_ERROR};
        case (c)
            CH_LPAREN: r = {1'b1, KIND_LPAREN};
            CH_RPAREN: r = {1'b1, KIND_RPAREN};
            CH_LBRACE: r = {1'b1, KIND_LBRACE};
            CH_RBRACE: r = {1'b1, KIND_RBRACE};
            CH_SEMI:   r = {1'b1, KIND_SEMI};
            CH_COMMA:  r = {1'b1, KIND_COMMA};
            CH_DOT:    r = {1'b1, KIND_DOT};
            CH_MINUS:  r = {1'b1, KIND_MINUS};
            CH_PLUS:   r = {1'b1, KIND_PLUS};
            CH_SLASH:  r = {1'b1, KIND_SLASH};
            CH_STAR:   r = {1'b1, KIND_STAR};
            default:   r = {1'b0, KIND_ERROR};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/plx_scan.sv
// Scanner state registers and the single-pass token logic for one character.
`default_nettype none

module plx_scan import plx_pkg::*; #(
    parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    accept,
    input  wire in_t     item,
    output bundle_t      bundle
);

    scan_mode_t             mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] ts_reg, ts_next;
    logic [OFFSET_BITS-1:0] cur_reg, cur_next;
    logic [15:0]            line_reg, line_next;

    logic [7:0]             c;
    logic                   is_nl, is_ws, is_slash, is_dot, is_digit;
    logic [4:0]             punct;
    logic [OFFSET_BITS-1:0] cur_bump, dot_off, num_end, len_a;
    logic                   do_flush, do_fresh, fresh_emits;
    logic                   v_a, v_b, v_c;
    tok_t                   tok_a, tok_b, tok_c;

    // Character classes.
    assign c        = item.char_code;
    assign is_nl    = (c == CH_NL);
    assign is_ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    assign is_slash = (c == CH_SLASH);
    assign is_dot   = (c == CH_DOT);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign punct    = punct_lookup(c);

    // Offset arithmetic; the offset counter saturates at all ones.
    assign cur_bump = (&cur_reg) ? cur_reg : cur_reg + 1'b1;
    assign dot_off  = (cur_reg > ts_reg) ? cur_reg - 1'b1 : cur_reg;
    assign num_end  = (mode_reg == MODE_INT_DOT) ? dot_off : cur_reg;
    assign len_a    = (num_end > ts_reg) ? num_end - ts_reg : '0;

    // Mode transitions and counter updates.
    always_comb begin
        mode_next = mode_reg;
        ts_next   = ts_reg;
        cur_next  = cur_reg;
        line_next = line_reg;
        do_flush  = 1'b0;
        do_fresh  = 1'b0;

        if (item.is_end) begin
            // Flush the pending token, emit end of file, return to reset values.
            do_flush  = 1'b1;
            mode_next = MODE_NORMAL;
            ts_next   = '0;
            cur_next  = '0;
            line_next = 16'd1;
        end else begin
            unique case (mode_reg)
                MODE_COMMENT: begin
                    if (is_nl) do_fresh = 1'b1;
                    else cur_next = cur_bump;
                end
                MODE_SLASH: begin
                    if (is_slash) begin
                        mode_next = MODE_COMMENT;
                        cur_next  = cur_bump;
                    end else begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                MODE_INT: begin
                    if (is_digit) begin
                        cur_next = cur_bump;
                    end else if (is_dot) begin
                        mode_next = MODE_INT_DOT;
                        cur_next  = cur_bump;
                    end else begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                MODE_INT_DOT: begin
                    if (is_digit) begin
                        mode_next = MODE_FRAC;
                        cur_next  = cur_bump;
                    end else begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                MODE_FRAC: begin
                    if (is_digit) begin
                        cur_next = cur_bump;
                    end else begin
                        do_flush = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                default: begin
                    do_fresh = 1'b1;
                end
            endcase

            // Scan the character with nothing pending.
            if (do_fresh) begin
                mode_next = MODE_NORMAL;
                cur_next  = cur_bump;
                if (is_nl) begin
                    if (line_reg != 16'hFFFF) line_next = line_reg + 16'd1;
                end else if (is_ws) begin
                    line_next = line_reg;
                end else if (is_slash) begin
                    mode_next = MODE_SLASH;
                    ts_next   = cur_reg;
                end else if (is_digit) begin
                    mode_next = MODE_INT;
                    ts_next   = cur_reg;
                end else begin
                    ts_next = cur_reg;
                end
            end
        end
    end

    // Tokens: a pending slash or number, a split-off dot, then the new one.
    assign fresh_emits = !is_nl && !is_ws && !is_slash && !is_digit;
    assign v_a = do_flush && (mode_reg inside {MODE_SLASH, MODE_INT, MODE_INT_DOT, MODE_FRAC});
    assign v_b = do_flush && (mode_reg == MODE_INT_DOT);
    assign v_c = item.is_end || (do_fresh && fresh_emits);

    assign tok_a.kind   = (mode_reg == MODE_SLASH) ? KIND_SLASH : KIND_NUMBER;
    assign tok_a.offset = clamp16(32'(ts_reg));
    assign tok_a.length = clamp16(32'(len_a));
    assign tok_a.line   = line_reg;

    assign tok_b.kind   = KIND_DOT;
    assign tok_b.offset = clamp16(32'(dot_off));
    assign tok_b.length = 16'd1;
    assign tok_b.line   = line_reg;

    assign tok_c.kind   = item.is_end ? KIND_EOF : punct[3:0];
    assign tok_c.offset = clamp16(32'(cur_reg));
    assign tok_c.length = item.is_end ? 16'd0 : 16'd1;
    assign tok_c.line   = line_reg;

    // Pack the valid tokens into consecutive slots.
    assign bundle.count   = {1'b0, v_a} + {1'b0, v_b} + {1'b0, v_c};
    assign bundle.slot[0] = v_a ? tok_a : tok_c;
    assign bundle.slot[1] = v_b ? tok_b : tok_c;
    assign bundle.slot[2] = tok_c;

    // Scanner state register, updated on each input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            ts_reg   <= '0;
            cur_reg  <= '0;
            line_reg <= 16'd1;
        end else if (accept) begin
            mode_reg <= mode_next;
            ts_reg   <= ts_next;
            cur_reg  <= cur_next;
            line_reg <= line_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/plx_outq.sv
// Two-entry token bundle queue that hands out one token per result transfer.
`default_nettype none

module plx_outq import plx_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire bundle_t push_data,
    output logic         in_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    output out_t         m_data
);

    bundle_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic [1:0] idx_reg, idx_next;
    bundle_t    head;
    tok_t       tok;
    logic       last, pop;

    // Head bundle and the token currently offered.
    assign head     = entry_reg[rd_ptr_reg];
    assign tok      = head.slot[idx_reg];
    assign last     = (idx_reg == head.count - 2'd1);
    assign m_valid  = (fill_reg != 2'd0);
    assign in_ready = (fill_reg != 2'd2);
    assign pop      = m_valid && m_ready && last;

    assign m_data.token_kind   = tok.kind;
    assign m_data.token_offset = tok.offset;
    assign m_data.token_length = tok.length;
    assign m_data.line_number  = tok.line;
    assign m_data.last_of_run  = last;

    // Pointer, fill and slot index updates.
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
        if (pop) idx_next = 2'd0;
        else if (m_valid && m_ready) idx_next = idx_reg + 2'd1;
        else idx_next = idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            idx_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            idx_reg    <= idx_next;
        end
    end

    // Bundle storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_data;
    end

    // The fill count never goes past two bundles.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg != 2'd3)
        else $error("bundle queue fill count out of range");

    // A bundle in the queue always holds at least one token.
    a_head_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> head.count != 2'd0)
        else $error("empty bundle reached the queue head");

    // The token index stays inside the head bundle.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> idx_reg < head.count)
        else $error("token index beyond bundle count");

    // Retiring a bundle rewinds the token index.
    a_pop_rewind: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> idx_reg == 2'd0)
        else $error("token index not cleared after bundle retired");

endmodule

`default_nettype wire

// File: hdl/punctuation_number_lexer.sv
// Top level of the punctuation and number lexer: scanner plus token output queue.
// The tokens of a character are registered in the token bundle queue on its transfer, then offered on m_.
// One character is accepted per cycle while the queue has room; a character that yields n tokens
// (n up to 3) leaves as n result transfers, and one that yields none adds no result transfers.
// The input is stalled only while the two-entry token bundle queue is full.
// Reset (aresetn low, synchronous): normal mode, offsets 0, line 1, queue empty.
`default_nettype none

module punctuation_number_lexer import plx_pkg::*; #(
    parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic    accept;
    logic    push;
    bundle_t bundle;

    // An input transfer updates the scanner and queues its tokens, if any.
    assign accept = s_valid && s_ready;
    assign push   = accept && (bundle.count != 2'd0);

    plx_scan #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_data),
        .bundle  (bundle)
    );

    plx_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (bundle),
        .in_ready  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// File: verif/tb_punctuation_number_lexer.sv
// Self-checking testbench for the punctuation and number lexer: directed table, random phases, directed tail.
`timescale 1ns / 100ps

module tb_punctuation_number_lexer import plx_pkg::*; ();

    localparam logic [15:0] OFF_MAX      = 16'hFFFF;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 8;

    // Clock, reset and the two channels.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    punctuation_number_lexer DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Scanner state as the predictor tracks it.
    scan_mode_t  lex_mode  = MODE_NORMAL;
    logic [15:0] lex_start = '0;
    logic [15:0] lex_off   = '0;
    logic [15:0] lex_line  = 16'd1;

    out_t step_toks[$];
    out_t tokens_due[$];

    int errors        = 0;
    int items_fed     = 0;
    int ends_fed      = 0;
    int tokens_seen   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    typedef struct {
        in_t  item;
        bit   typed;
        out_t tok;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic in_t char_item(input logic [7:0] c, input logic e);
        in_t it;
        it.char_code = c;
        it.is_end    = e;
        return it;
    endfunction

    // Directed row; a typed row yields exactly one token of length 1 on line 1.
    function automatic dir_row_t make_row(input logic [7:0] c, input logic e, input bit typed,
                                          input logic [3:0] kind, input logic [15:0] off);
        dir_row_t r;
        r.item  = char_item(c, e);
        r.typed = typed;
        r.tok   = '{token_kind: kind, token_offset: off, token_length: 16'd1,
                    line_number: 16'd1, last_of_run: 1'b1};
        return r;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [15:0] span_to(input logic [15:0] stop);
        return (stop > lex_start) ? stop - lex_start : 16'd0;
    endfunction

    task automatic push_tok(input logic [3:0] kind, input logic [15:0] off,
                            input logic [15:0] len);
        out_t t;
        t = '{token_kind: kind, token_offset: off, token_length: len,
              line_number: lex_line, last_of_run: 1'b0};
        step_toks.push_back(t);
    endtask

    task automatic bump_off();
        if (lex_off != OFF_MAX) lex_off = lex_off + 16'd1;
    endtask

    // Emit the token held by a pending mode and fall back to normal.
    task automatic flush_mode();
        logic [15:0] dot_at;
        case (lex_mode)
            MODE_SLASH: begin
                push_tok(KIND_SLASH, lex_start, span_to(lex_off));
            end
            MODE_INT, MODE_FRAC: begin
                push_tok(KIND_NUMBER, lex_start, span_to(lex_off));
            end
            MODE_INT_DOT: begin
                dot_at = (lex_off > lex_start) ? lex_off - 16'd1 : lex_off;
                push_tok(KIND_NUMBER, lex_start, span_to(dot_at));
                push_tok(KIND_DOT, dot_at, 16'd1);
            end
            default: begin
            end
        endcase
        lex_mode = MODE_NORMAL;
    endtask

    // Scan a character with nothing pending.
    task automatic scan_char(input logic [7:0] c);
        logic [3:0] kind;
        if (c == CH_NL) begin
            if (lex_line != 16'hFFFF) lex_line = lex_line + 16'd1;
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
            // Whitespace only advances the offset.
        end else if (c == CH_SLASH) begin
            lex_mode  = MODE_SLASH;
            lex_start = lex_off;
        end else if (is_digit(c)) begin
            lex_mode  = MODE_INT;
            lex_start = lex_off;
        end else begin
            lex_start = lex_off;
            case (c)
                CH_LPAREN: kind = KIND_LPAREN;
                CH_RPAREN: kind = KIND_RPAREN;
                CH_LBRACE: kind = KIND_LBRACE;
                CH_RBRACE: kind = KIND_RBRACE;
                CH_SEMI:   kind = KIND_SEMI;
                CH_COMMA:  kind = KIND_COMMA;
                CH_DOT:    kind = KIND_DOT;
                CH_MINUS:  kind = KIND_MINUS;
                CH_PLUS:   kind = KIND_PLUS;
                CH_STAR:   kind = KIND_STAR;
                default:   kind = KIND_ERROR;
            endcase
            push_tok(kind, lex_off, 16'd1);
        end
        bump_off();
    endtask

    // Work out the tokens one accepted character causes, in order, into step_toks.
    task automatic predict_tokens(input in_t it);
        logic [7:0] c;
        c = it.char_code;
        step_toks.delete();
        if (it.is_end) begin
            if (lex_mode == MODE_COMMENT) lex_mode = MODE_NORMAL;
            flush_mode();
            push_tok(KIND_EOF, lex_off, 16'd0);
            lex_mode  = MODE_NORMAL;
            lex_start = '0;
            lex_off   = '0;
            lex_line  = 16'd1;
        end else begin
            case (lex_mode)
                MODE_COMMENT: begin
                    if (c == CH_NL) begin
                        lex_mode = MODE_NORMAL;
                        scan_char(c);
                    end else begin
                        bump_off();
                    end
                end
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        lex_mode = MODE_COMMENT;
                        bump_off();
                    end else begin
                        flush_mode();
                        scan_char(c);
                    end
                end
                MODE_INT: begin
                    if (is_digit(c)) begin
                        bump_off();
                    end else if (c == CH_DOT) begin
                        lex_mode = MODE_INT_DOT;
                        bump_off();
                    end else begin
                        flush_mode();
                        scan_char(c);
                    end
                end
                MODE_INT_DOT, MODE_FRAC: begin
                    if (is_digit(c)) begin
                        lex_mode = MODE_FRAC;
                        bump_off();
                    end else begin
                        flush_mode();
                        scan_char(c);
                    end
                end
                default: begin
                    lex_mode = MODE_NORMAL;
                    scan_char(c);
                end
            endcase
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_of_run = 1'b1;
    endtask

    // Offer one character, wait for its transfer, then queue the tokens it causes.
    // A typed row supplies its own expected token in place of the prediction.
    task automatic feed(input in_t item, input bit typed, input out_t typed_tok);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_tokens(item);
        if (typed) begin
            tokens_due.push_back(typed_tok);
        end else begin
            foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
        end
        items_fed++;
        if (item.is_end) ends_fed++;
    endtask

    // Stop offering and wait for every queued token to come out.
    task automatic drain();
        s_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One random source fragment: mostly well-formed lexemes, some noise.
    task automatic feed_fragment();
        int         pick;
        int         n;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            case ($urandom_range(0, 10))
                0:       c = CH_LPAREN;
                1:       c = CH_RPAREN;
                2:       c = CH_LBRACE;
                3:       c = CH_RBRACE;
                4:       c = CH_SEMI;
                5:       c = CH_COMMA;
                6:       c = CH_DOT;
                7:       c = CH_MINUS;
                8:       c = CH_PLUS;
                9:       c = CH_SLASH;
                default: c = CH_STAR;
            endcase
            feed(char_item(c, 1'b0), 1'b0, '0);
        end else if (pick < 42) begin
            // Number: integer part, then maybe a dot with zero or more digits.
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
            repeat (n) feed(char_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0), 1'b0, '0);
            if ($urandom_range(0, 1) == 1) begin
                feed(char_item(CH_DOT, 1'b0), 1'b0, '0);
                repeat ($urandom_range(0, 3))
                    feed(char_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0), 1'b0, '0);
            end
        end else if (pick < 50) begin
            // Line comment with random body, usually closed by a newline.
            feed(char_item(CH_SLASH, 1'b0), 1'b0, '0);
            feed(char_item(CH_SLASH, 1'b0), 1'b0, '0);
            repeat ($urandom_range(0, 4))
                feed(char_item(8'($urandom_range(0, 255)), 1'b0), 1'b0, '0);
            if ($urandom_range(0, 3) != 0) feed(char_item(CH_NL, 1'b0), 1'b0, '0);
        end else if (pick < 68) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 3))
                    0:       c = CH_SPACE;
                    1:       c = CH_TAB;
                    2:       c = CH_CR;
                    default: c = CH_NL;
                endcase
                feed(char_item(c, 1'b0), 1'b0, '0);
            end
        end else if (pick < 95) begin
            feed(char_item(8'($urandom_range(0, 255)), 1'b0), 1'b0, '0);
        end else begin
            feed(char_item(8'($urandom_range(0, 255)), 1'b1), 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int n_items);
        int first;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        first = items_fed;
        while (items_fed - first < n_items) feed_fragment();
        drain();
    endtask

    // Receiver: random stalls, plus a long hold-off each time one is requested.
    always @(posedge aclk) begin
        if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each token transfer with the oldest expected token.
    always @(posedge aclk) begin
        out_t want;
        bit   bad;
        if (aresetn && m_valid && m_ready) begin
            tokens_seen++;
            if (tokens_due.size() == 0) begin
                $error("unexpected token: kind %0d offset %0d", m_data.token_kind,
                       m_data.token_offset);
                errors++;
            end else begin
                want = tokens_due.pop_front();
                bad  = 1'b0;
                if (m_data.token_kind !== want.token_kind) begin
                    $error("token_kind: expected %0d, got %0d", want.token_kind,
                           m_data.token_kind);
                    bad = 1'b1;
                end
                if (m_data.token_offset !== want.token_offset) begin
                    $error("token_offset: expected %0d, got %0d", want.token_offset,
                           m_data.token_offset);
                    bad = 1'b1;
                end
                if (m_data.token_length !== want.token_length) begin
                    $error("token_length: expected %0d, got %0d", want.token_length,
                           m_data.token_length);
                    bad = 1'b1;
                end
                if (m_data.line_number !== want.line_number) begin
                    $error("line_number: expected %0d, got %0d", want.line_number,
                           m_data.line_number);
                    bad = 1'b1;
                end
                if (m_data.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                           m_data.last_of_run);
                    bad = 1'b1;
                end
                if (bad) errors++;
            end
        end
    end

    // Run limit, well beyond the slowest correct run.
    initial begin
        #2_000_000;
        $error("timeout with %0d tokens still due", tokens_due.size());
        $display("status: fail");
        $finish;
    end

    // Main sequence.
    initial begin
        // Punctuation, extreme bytes, then the lookahead cases.
        dir_rows.push_back(make_row(CH_LPAREN, 1'b0, 1'b1, KIND_LPAREN, 16'd0));
        dir_rows.push_back(make_row(CH_RPAREN, 1'b0, 1'b1, KIND_RPAREN, 16'd1));
        dir_rows.push_back(make_row(CH_LBRACE, 1'b0, 1'b1, KIND_LBRACE, 16'd2));
        dir_rows.push_back(make_row(CH_RBRACE, 1'b0, 1'b1, KIND_RBRACE, 16'd3));
        dir_rows.push_back(make_row(CH_SEMI,   1'b0, 1'b1, KIND_SEMI,   16'd4));
        dir_rows.push_back(make_row(CH_COMMA,  1'b0, 1'b1, KIND_COMMA,  16'd5));
        dir_rows.push_back(make_row(CH_DOT,    1'b0, 1'b1, KIND_DOT,    16'd6));
        dir_rows.push_back(make_row(CH_MINUS,  1'b0, 1'b1, KIND_MINUS,  16'd7));
        dir_rows.push_back(make_row(CH_PLUS,   1'b0, 1'b1, KIND_PLUS,   16'd8));
        dir_rows.push_back(make_row(CH_STAR,   1'b0, 1'b1, KIND_STAR,   16'd9));
        // The zero byte and the all-ones byte are both errors.
        dir_rows.push_back(make_row(8'h00,     1'b0, 1'b1, KIND_ERROR,  16'd10));
        dir_rows.push_back(make_row(8'hFF,     1'b0, 1'b1, KIND_ERROR,  16'd11));
        dir_rows.push_back(make_row(CH_TAB,    1'b0, 1'b0, KIND_ERROR,  16'd0));
        // A digit, a dot, then a non-digit: number, dot and error in one transfer.
        dir_rows.push_back(make_row(CH_ZERO + 8'd4, 1'b0, 1'b0, KIND_ERROR, 16'd0));
        dir_rows.push_back(make_row(CH_DOT,    1'b0, 1'b0, KIND_ERROR,  16'd0));
        dir_rows.push_back(make_row(8'h23,     1'b0, 1'b0, KIND_ERROR,  16'd0)); // '#'
        // A number pending at a newline keeps the old line number.
        dir_rows.push_back(make_row(CH_NINE,   1'b0, 1'b0, KIND_ERROR,  16'd0));
        dir_rows.push_back(make_row(CH_NL,     1'b0, 1'b0, KIND_ERROR,  16'd0));
        // A lone slash followed by a fraction.
        dir_rows.push_back(make_row(CH_SLASH,  1'b0, 1'b0, KIND_ERROR,  16'd0));
        dir_rows.push_back(make_row(CH_ZERO + 8'd3, 1'b0, 1'b0, KIND_ERROR, 16'd0));
        dir_rows.push_back(make_row(CH_DOT,    1'b0, 1'b0, KIND_ERROR,  16'd0));
        dir_rows.push_back(make_row(CH_ZERO + 8'd5, 1'b0, 1'b0, KIND_ERROR, 16'd0));
        dir_rows.push_back(make_row(CH_CR,     1'b0, 1'b0, KIND_ERROR,  16'd0));
        // A comment still open at the end emits nothing before the end marker.
        dir_rows.push_back(make_row(CH_SLASH,  1'b0, 1'b0, KIND_ERROR,  16'd0));
        dir_rows.push_back(make_row(CH_SLASH,  1'b0, 1'b0, KIND_ERROR,  16'd0));
        dir_rows.push_back(make_row(8'h78,     1'b0, 1'b0, KIND_ERROR,  16'd0)); // 'x'
        dir_rows.push_back(make_row(8'hFF,     1'b1, 1'b0, KIND_ERROR,  16'd0));
        // The end marker returns the scanner to its reset state.
        dir_rows.push_back(make_row(CH_PLUS,   1'b0, 1'b1, KIND_PLUS,   16'd0));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) feed(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].tok);
        drain();

        run_phase(32, 85, 140);
        run_phase(85, 32, 130);

        // Long receiver hold-off while characters keep coming, so the input stalls.
        hold_token <= hold_token + 1;
        run_phase(0, 0, 130);

        // A mixed tail: punctuation, numbers, a split-off dot and a slash still
        // pending when the end marker arrives.
        feed(char_item(CH_LPAREN, 1'b0), 1'b0, '0);
        feed(char_item(CH_ZERO + 8'd1, 1'b0), 1'b0, '0);
        feed(char_item(CH_ZERO + 8'd2, 1'b0), 1'b0, '0);
        feed(char_item(CH_SEMI, 1'b0), 1'b0, '0);
        feed(char_item(CH_ZERO + 8'd7, 1'b0), 1'b0, '0);
        feed(char_item(CH_DOT, 1'b0), 1'b0, '0);
        feed(char_item(8'h78, 1'b0), 1'b0, '0);
        feed(char_item(CH_SLASH, 1'b0), 1'b0, '0);
        feed(char_item(8'h00, 1'b1), 1'b0, '0);
        drain();

        if (tokens_due.size() != 0) begin
            $error("%0d expected tokens never arrived", tokens_due.size());
            errors++;
        end

        $display("Fed %0d characters (%0d end markers) and checked %0d tokens;",
                 items_fed, ends_fed, tokens_seen);
        $display("covered punctuation, numbers, comments, end markers and long stalls.");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/plx_pkg.sv
hdl/plx_scan.sv
hdl/plx_outq.sv
hdl/punctuation_number_lexer.sv
verif/tb_punctuation_number_lexer.sv
